>>> src/easter_holy_day_dates_unit_assert.svh
// Assertion macros for the Easter holy day dates unit.
`ifndef EASTER_HOLY_DAY_DATES_UNIT_ASSERT_SVH
`define EASTER_HOLY_DAY_DATES_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define EHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("easter unit: implication check failed");

// Next-cycle implication, checked outside reset.
`define EHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("easter unit: next-cycle check failed");

`else

`define EHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/ehd_pkg.sv
// Package: types, constants and calendar helpers for the Easter holy day dates unit.
package ehd_pkg;

    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned PIPE_DEPTH = 16;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // reciprocal multipliers for the constant divisions
    localparam logic [12:0] RECIP_100 = 13'd5243;  // >> 19
    localparam logic [5:0]  RECIP_25  = 6'd41;     // >> 10
    localparam logic [11:0] RECIP_19  = 12'd3450;  // >> 16
    localparam logic [7:0]  RECIP_3   = 8'd171;    // >> 9
    localparam logic [8:0]  RECIP_30  = 9'd273;    // >> 13, one correction step
    localparam logic [7:0]  RECIP_7   = 8'd147;    // >> 10

    typedef enum logic [2:0] {
        FEAST_EASTER      = 3'd0,
        FEAST_CARNIVAL    = 3'd1,
        FEAST_GOOD_FRIDAY = 3'd2,
        FEAST_WHITSUN     = 3'd3,
        FEAST_ASCENSION   = 3'd4
    } feast_t;

    // one record travels down the pipe; each stage fills in its own fields
    typedef struct packed {
        logic [YEAR_W-1:0] y;
        logic [6:0]        b;
        logic [6:0]        c;
        logic [2:0]        f;
        logic [9:0]        s;
        logic [6:0]        x;
        logic [4:0]        qa;
        logic [5:0]        g;
        logic [4:0]        a;
        logic [8:0]        t;
        logic [3:0]        qh;
        logic [4:0]        h;
        logic [6:0]        u;
        logic [3:0]        ql;
        logic [2:0]        l;
        logic              m;
        logic [7:0]        base;
        logic              april;
        logic [4:0]        eday;
        logic              leap;
        logic [8:0]        edoy;
    } pipe_t;

    // day of year on which month mon ends; mon 0 gives 0
    function automatic logic [8:0] month_end(input logic [3:0] mon, input logic leap);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            4'd12:   d = 9'd365;
            default: d = 9'd0;
        endcase
        if (leap && mon >= 4'd2) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    // day offset from Easter, two's complement in nine bits
    function automatic logic [8:0] feast_offset(input feast_t k);
        logic [8:0] o;
        unique case (k)
            FEAST_EASTER:      o = 9'd0;
            FEAST_CARNIVAL:    o = 9'd0 - 9'd49;
            FEAST_GOOD_FRIDAY: o = 9'd0 - 9'd2;
            FEAST_WHITSUN:     o = 9'd49;
            FEAST_ASCENSION:   o = 9'd39;
            default:           o = 9'd0;
        endcase
        return o;
    endfunction

endpackage

>>> src/easter_holy_day_dates_unit.sv
// Top level: pipelined Easter computus and feast date generator.
//
// Takes one Gregorian year per input beat (clamped into 1583..9999) and gives five
// result beats: Easter, Carnival (Easter-49), Good Friday (Easter-2), Whitsuntide
// (Easter+49) and Ascension (Whitsuntide-10), each with day of month, month and
// day of year; the Ascension beat carries last_of_run. The Meeus/Jones/Butcher
// arithmetic runs through a 16-stage pipeline with constant-reciprocal divisions.
// A generator stage then issues the five beats, one per cycle while the result
// channel takes them, into a registered output; later years wait in the pipe while
// the beats of one year are issued. The pipe advances as a whole when the
// generator is empty or hands out its final beat; s_ready follows that condition.
// There is no configuration and no state beyond the pipeline, the generator and
// the output register.
`include "easter_holy_day_dates_unit_assert.svh"

module easter_holy_day_dates_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ehd_pkg::YEAR_W-1:0] s_year,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_feast,
    output logic [4:0]                m_day_of_month,
    output logic [3:0]                m_month_number,
    output logic [8:0]                m_year_day,
    output logic                      m_last_of_run
);
    import ehd_pkg::*;

    // pipeline
    pipe_t                 pipe_reg  [PIPE_DEPTH];
    pipe_t                 pipe_next [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0] pipe_valid_reg;

    // beat generator
    logic       gen_valid_reg;
    feast_t     gen_idx_reg;
    logic [8:0] gen_edoy_reg;
    logic       gen_leap_reg;

    // output register
    logic       m_valid_reg;
    feast_t     m_feast_reg,  m_feast_next;
    logic [4:0] m_day_reg,    m_day_next;
    logic [3:0] m_month_reg,  m_month_next;
    logic [8:0] m_doy_reg,    m_doy_next;
    logic       m_last_reg,   m_last_next;

    logic out_free, out_load, advance;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = gen_valid_reg && out_free;
    // advance the whole pipe when the generator can take a new year
    assign advance  = !gen_valid_reg || (out_load && gen_idx_reg == FEAST_ASCENSION);
    assign s_ready  = advance;

    // stage arithmetic
    always_comb begin
        logic [26:0] prod_b;
        logic [13:0] prod_c;
        logic [12:0] prod_f;
        logic [21:0] prod_a;
        logic [14:0] prod_g;
        logic [17:0] prod_h;
        logic [8:0]  rem_h;
        logic [14:0] prod_l;
        logic [9:0]  sum_m;

        pipe_next[0] = '0;
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            pipe_next[i] = pipe_reg[i-1];
        end

        // clamp the year
        priority if (s_year < YEAR_MIN) begin
            pipe_next[0].y = YEAR_MIN;
        end else if (s_year > YEAR_MAX) begin
            pipe_next[0].y = YEAR_MAX;
        end else begin
            pipe_next[0].y = s_year;
        end

        // century b = y / 100
        prod_b = 27'(pipe_reg[0].y) * 27'(RECIP_100);
        pipe_next[1].b = prod_b[25:19];

        // c = y % 100, f = (b + 8) / 25
        prod_c = 14'(pipe_reg[1].b) * 14'd100;
        pipe_next[2].c = 7'(pipe_reg[1].y - prod_c);
        prod_f = (13'(pipe_reg[1].b) + 13'd8) * 13'(RECIP_25);
        pipe_next[2].f = prod_f[12:10];

        // s = 5b + c folds y into a small value with the same residue mod 19
        pipe_next[3].s = 10'(pipe_reg[2].b) * 10'd5 + 10'(pipe_reg[2].c);
        pipe_next[3].x = pipe_reg[2].b - 7'(pipe_reg[2].f) + 7'd1;

        // quotients for a and g
        prod_a = 22'(pipe_reg[3].s) * 22'(RECIP_19);
        pipe_next[4].qa = prod_a[20:16];
        prod_g = 15'(pipe_reg[3].x) * 15'(RECIP_3);
        pipe_next[4].g = prod_g[14:9];

        // a = y % 19
        pipe_next[5].a = 5'(pipe_reg[4].s - 10'(pipe_reg[4].qa) * 10'd19);

        // t = 19a + b + 15 - d - g, never negative in range
        pipe_next[6].t = 9'(10'(pipe_reg[5].a) * 10'd19 + 10'(pipe_reg[5].b) + 10'd15
                            - 10'(pipe_reg[5].b[6:2]) - 10'(pipe_reg[5].g));

        // quotient estimate for t / 30, low by at most one
        prod_h = 18'(pipe_reg[6].t) * 18'(RECIP_30);
        pipe_next[7].qh = prod_h[16:13];

        // h = t % 30 with one correction
        rem_h = pipe_reg[7].t - 9'(pipe_reg[7].qh) * 9'd30;
        pipe_next[8].h = (rem_h >= 9'd30) ? 5'(rem_h - 9'd30) : 5'(rem_h);

        // u = 32 + 2e + 2i - h - k
        pipe_next[9].u = 7'd32 + (7'(pipe_reg[8].b[1:0]) << 1) + (7'(pipe_reg[8].c[6:2]) << 1)
                         - 7'(pipe_reg[8].h) - 7'(pipe_reg[8].c[1:0]);

        prod_l = 15'(pipe_reg[9].u) * 15'(RECIP_7);
        pipe_next[10].ql = prod_l[13:10];

        // l = u % 7
        pipe_next[11].l = 3'(pipe_reg[10].u - 7'(pipe_reg[10].ql) * 7'd7);

        // m = (a + 11h + 22l) / 451 is 0 or 1
        sum_m = 10'(pipe_reg[11].a) + 10'(pipe_reg[11].h) * 10'd11
              + 10'(pipe_reg[11].l) * 10'd22;
        pipe_next[12].m = (sum_m >= 10'd451);

        // base = 31*month + day - 1
        pipe_next[13].base = 8'(pipe_reg[12].h) + 8'(pipe_reg[12].l) + 8'd114
                           - (pipe_reg[12].m ? 8'd7 : 8'd0);

        // split into March or April, and the leap-year rule
        pipe_next[14].april = (pipe_reg[13].base >= 8'd124);
        pipe_next[14].eday  = 5'(pipe_reg[13].base
                              - (pipe_next[14].april ? 8'd124 : 8'd93) + 8'd1);
        pipe_next[14].leap  = (pipe_reg[13].c == 7'd0) ? (pipe_reg[13].b[1:0] == 2'd0)
                                                       : (pipe_reg[13].c[1:0] == 2'd0);

        // Easter day of year
        pipe_next[15].edoy = 9'(pipe_reg[14].eday) + (pipe_reg[14].leap ? 9'd60 : 9'd59)
                           + (pipe_reg[14].april ? 9'd31 : 9'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
        end else if (advance) begin
            pipe_valid_reg <= {pipe_valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // generator: take a finished year, then step through the five feasts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_valid_reg <= 1'b0;
            gen_idx_reg   <= FEAST_EASTER;
        end else if (advance) begin
            gen_valid_reg <= pipe_valid_reg[PIPE_DEPTH-1];
            gen_idx_reg   <= FEAST_EASTER;
        end else if (out_load) begin
            gen_idx_reg   <= feast_t'(gen_idx_reg + 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gen_edoy_reg <= pipe_reg[PIPE_DEPTH-1].edoy;
            gen_leap_reg <= pipe_reg[PIPE_DEPTH-1].leap;
        end
    end

    // date of the current feast
    always_comb begin
        logic [8:0] doy;
        logic [3:0] mon;

        doy = gen_edoy_reg + feast_offset(gen_idx_reg);
        mon = 4'd12;
        for (int i = 11; i >= 1; i--) begin
            if (doy <= month_end(4'(i), gen_leap_reg)) begin
                mon = 4'(i);
            end
        end
        m_feast_next = gen_idx_reg;
        m_doy_next   = doy;
        m_month_next = mon;
        m_day_next   = 5'(doy - month_end(mon - 4'd1, gen_leap_reg));
        m_last_next  = (gen_idx_reg == FEAST_ASCENSION);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_feast_reg <= m_feast_next;
            m_day_reg   <= m_day_next;
            m_month_reg <= m_month_next;
            m_doy_reg   <= m_doy_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_feast        = m_feast_reg;
    assign m_day_of_month = m_day_reg;
    assign m_month_number = m_month_reg;
    assign m_year_day     = m_doy_reg;
    assign m_last_of_run  = m_last_reg;

    // a new year enters only when the generator is empty or on its final beat
    `EHD_ASSERT_IMP(a_accept_gen_free, aclk, aresetn, s_ready,
        !gen_valid_reg || gen_idx_reg == FEAST_ASCENSION)
    // last_of_run marks Ascension and nothing else
    `EHD_ASSERT_IMP(a_last_is_ascension, aclk, aresetn, m_valid,
        m_last_of_run == (m_feast == FEAST_ASCENSION))
    // every feast lands between February 1 and mid June
    `EHD_ASSERT_IMP(a_date_window, aclk, aresetn, m_valid,
        m_year_day >= 9'd32 && m_year_day <= 9'd166 && m_month_number >= 4'd2
        && m_month_number <= 4'd6 && m_day_of_month != 5'd0)
    // generator steps one feast per loaded beat
    `EHD_ASSERT_NXT(a_gen_step, aclk, aresetn,
        out_load && gen_idx_reg != FEAST_ASCENSION,
        gen_idx_reg == feast_t'($past(gen_idx_reg) + 3'd1))

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the Easter holy day dates unit: table-driven years, then random years.
module tb_top;
    import ehd_pkg::*;

    localparam int unsigned HOLD_CYCLES   = 200;  // long receiver hold-off, fills the pipe
    localparam int unsigned SETTLE_CYCLES = 40;   // settle time after draining, beyond the first-result latency
    localparam int unsigned TABLE_ROWS    = 22;

    // One result beat as the unit should present it.
    typedef struct packed {
        feast_t     feast;
        logic [4:0] dom;
        logic [3:0] mon;
        logic [8:0] doy;
        logic       last;
    } feast_date_t;

    // One row of the directed table. Where pinned is set, the Easter beat of that
    // year is taken from the row rather than from the date calculator below.
    typedef struct packed {
        logic [13:0] year;
        logic        pinned;
        logic [4:0]  dom;
        logic [3:0]  mon;
        logic [8:0]  doy;
    } year_case_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [YEAR_W-1:0] s_year         = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [2:0]        m_feast;
    logic [4:0]        m_day_of_month;
    logic [3:0]        m_month_number;
    logic [8:0]        m_year_day;
    logic              m_last_of_run;

    feast_date_t       pending_dates[$];
    int unsigned       mismatches     = 0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_idle_pct  = 0;
    bit                hold_request   = 1'b0;

    // Clamped years, extremes of the Easter window, leap and century years,
    // and years that need the late-April correction of the computus.
    year_case_t year_table [TABLE_ROWS] = '{
        '{14'd0,     1'b1, 5'd10, 4'd4, 9'd100},  // below range, clamps to 1583
        '{14'd1582,  1'b1, 5'd10, 4'd4, 9'd100},  // just below range
        '{14'd1583,  1'b1, 5'd10, 4'd4, 9'd100},  // first year of the range
        '{14'd9999,  1'b1, 5'd28, 4'd3, 9'd87},   // last year of the range
        '{14'd10000, 1'b1, 5'd28, 4'd3, 9'd87},   // just above range
        '{14'd16383, 1'b1, 5'd28, 4'd3, 9'd87},   // all ones, clamps to 9999
        '{14'h2AAA,  1'b1, 5'd28, 4'd3, 9'd87},   // alternating bits, above range
        '{14'h1555,  1'b0, 5'd0,  4'd0, 9'd0},    // alternating bits, in range
        '{14'd1818,  1'b1, 5'd22, 4'd3, 9'd81},   // earliest possible Easter
        '{14'd2285,  1'b1, 5'd22, 4'd3, 9'd81},   // earliest possible Easter
        '{14'd1943,  1'b1, 5'd25, 4'd4, 9'd115},  // latest possible Easter
        '{14'd2038,  1'b1, 5'd25, 4'd4, 9'd115},  // latest possible Easter
        '{14'd2000,  1'b1, 5'd23, 4'd4, 9'd114},  // century leap year
        '{14'd2016,  1'b0, 5'd0,  4'd0, 9'd0},    // leap year, Easter in March
        '{14'd2024,  1'b0, 5'd0,  4'd0, 9'd0},
        '{14'd1700,  1'b0, 5'd0,  4'd0, 9'd0},    // century, not leap
        '{14'd1900,  1'b0, 5'd0,  4'd0, 9'd0},
        '{14'd2400,  1'b0, 5'd0,  4'd0, 9'd0},
        '{14'd1954,  1'b0, 5'd0,  4'd0, 9'd0},    // late-April correction
        '{14'd1981,  1'b0, 5'd0,  4'd0, 9'd0},    // late-April correction
        '{14'd1600,  1'b0, 5'd0,  4'd0, 9'd0},
        '{14'd8888,  1'b0, 5'd0,  4'd0, 9'd0}
    };

    easter_holy_day_dates_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_year         (s_year),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_feast        (m_feast),
        .m_day_of_month (m_day_of_month),
        .m_month_number (m_month_number),
        .m_year_day     (m_year_day),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Date calculator
    // ------------------------------------------------------------------

    function automatic bit year_is_leap(input int yr);
        if (yr % 100 == 0) begin
            return (yr % 400) == 0;
        end
        return (yr % 4) == 0;
    endfunction

    function automatic int month_length(input int yr, input int mon);
        int n;
        case (mon)
            2:          n = year_is_leap(yr) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:    n = 31;
        endcase
        return n;
    endfunction

    // Signed day distance of each feast from Easter Sunday.
    function automatic int days_from_easter(input feast_t f);
        int d;
        case (f)
            FEAST_CARNIVAL:    d = -49;
            FEAST_GOOD_FRIDAY: d = -2;
            FEAST_WHITSUN:     d = 49;
            FEAST_ASCENSION:   d = 39;  // Whitsuntide less ten days
            default:           d = 0;
        endcase
        return d;
    endfunction

    // Work out the five feast beats of one accepted year and queue them in
    // the order the unit must give them.
    task automatic predict_feast_dates(input logic [13:0] raw_year);
        int          yr;
        int          golden, century, year_in_cent, cent_quarter, cent_rem;
        int          moon_corr, sun_corr, epact, quarter, quarter_rem;
        int          weekday_shift, late_corr, month_day_code;
        int          easter_mon, sunday_doy, doy, rem, mon;
        feast_date_t fd;

        yr = int'(raw_year);
        if (yr < int'(YEAR_MIN)) begin
            yr = int'(YEAR_MIN);
        end
        if (yr > int'(YEAR_MAX)) begin
            yr = int'(YEAR_MAX);
        end

        golden         = yr % 19;
        century        = yr / 100;
        year_in_cent   = yr % 100;
        cent_quarter   = century / 4;
        cent_rem       = century % 4;
        moon_corr      = (century + 8) / 25;
        sun_corr       = (century - moon_corr + 1) / 3;
        epact          = (19 * golden + century + 15 - cent_quarter - sun_corr) % 30;
        quarter        = year_in_cent / 4;
        quarter_rem    = year_in_cent % 4;
        weekday_shift  = (32 + 2 * cent_rem + 2 * quarter - epact - quarter_rem) % 7;
        late_corr      = (golden + 11 * epact + 22 * weekday_shift) / 451;
        // month times 31 plus day less one
        month_day_code = epact + weekday_shift + 114 - 7 * late_corr;

        easter_mon = month_day_code / 31;
        sunday_doy = month_day_code % 31 + 1;
        for (int m = 1; m < easter_mon; m++) begin
            sunday_doy += month_length(yr, m);
        end

        for (int k = 0; k < 5; k++) begin
            fd.feast = feast_t'(k);
            doy      = sunday_doy + days_from_easter(fd.feast);
            rem      = doy;
            mon      = 1;
            while (mon < 12 && rem > month_length(yr, mon)) begin
                rem -= month_length(yr, mon);
                mon++;
            end
            fd.dom  = rem[4:0];
            fd.mon  = mon[3:0];
            fd.doy  = doy[8:0];
            fd.last = (fd.feast == FEAST_ASCENSION);
            pending_dates.push_back(fd);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one year, with a random gap first when the sender is idling, and
    // hold it until the beat is taken. Valid stays high across back-to-back
    // beats, so only one assignment to s_valid happens per edge.
    task automatic send_year(input logic [13:0] yr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_year  <= yr;
        do @(posedge aclk); while (!s_ready);
        predict_feast_dates(yr);
    endtask

    // Mostly legal years; the rest below the range, above it, or any 14-bit value.
    function automatic logic [13:0] random_year();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return 14'($urandom_range(9999, 1583));
        end else if (pick < 88) begin
            return 14'($urandom_range(1582, 0));
        end else if (pick < 95) begin
            return 14'($urandom_range(16383, 10000));
        end
        return 14'($urandom);
    endfunction

    // Drop valid and wait for every outstanding beat to come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive ready from its own process. A hold-off request keeps ready low for
    // a long, counted stretch so that the pipe fills and s_ready drops.
    initial begin
        int unsigned held;
        bit          hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result beat, field by field, with the oldest expected beat.
    always @(posedge aclk) begin
        feast_date_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual feast %0d doy %0d",
                         $time, m_feast, m_year_day);
                mismatches++;
            end else begin
                want = pending_dates.pop_front();
                check_field("feast",        want.feast, m_feast);
                check_field("day_of_month", want.dom,   m_day_of_month);
                check_field("month_number", want.mon,   m_month_number);
                check_field("year_day",     want.doy,   m_year_day);
                check_field("last_of_run",  want.last,  m_last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        int unsigned easter_idx;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: sender idles a third of the time, receiver mostly stalls.
        send_idle_pct = 33;
        recv_idle_pct = 85;
        for (int r = 0; r < TABLE_ROWS; r++) begin
            send_year(year_table[r].year);
            if (year_table[r].pinned) begin
                // overwrite the Easter beat just queued with the known date
                easter_idx = pending_dates.size() - 5;
                pending_dates[easter_idx].dom = year_table[r].dom;
                pending_dates[easter_idx].mon = year_table[r].mon;
                pending_dates[easter_idx].doy = year_table[r].doy;
            end
        end
        for (int n = 0; n < 65; n++) begin
            send_year(random_year());
        end

        // Phase two: roles swapped; pause midway until the unit is empty.
        send_idle_pct = 85;
        recv_idle_pct = 33;
        for (int n = 0; n < 65; n++) begin
            if (n == 30) begin
                drain_results();
            end
            send_year(random_year());
        end

        // Phase three: no idling; a long receiver hold-off while years keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 70; n++) begin
            if (n == 10) begin
                hold_request = 1'b1;
            end
            send_year(random_year());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> easter_holy_day_dates_unit.f
+incdir+src
src/ehd_pkg.sv
src/easter_holy_day_dates_unit.sv
bench/tb_top.sv
